[src/tsf_pkg.sv]
`timescale 1ns / 1ps

package tsf_pkg;

   // click codes passed from the front end to the flasher back end
   typedef enum logic [2:0] {
      CLICK_NONE,
      CLICK_LSHORT,
      CLICK_LLONG,
      CLICK_RSHORT,
      CLICK_RLONG,
      CLICK_HAZARD,
      CLICK_PARTY
   } click_type;

   // flasher mode, also the rsp_mode_now code
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_LEFT,
      MODE_RIGHT,
      MODE_HAZARD,
      MODE_PARTY
   } mode_type;

   // side of the last short click inside the gesture window
   typedef enum logic [1:0] {
      SIDE_NONE,
      SIDE_LEFT,
      SIDE_RIGHT
   } side_type;

   // configuration register set
   typedef struct packed {
      logic [15:0] short_click_ticks;
      logic [15:0] long_click_ticks;
      logic [15:0] blink_half_period;
      logic [15:0] gesture_window;
      logic [15:0] party_on_ticks;
      logic [15:0] party_off_ticks;
      logic [7:0]  short_run_blinks;
      logic [7:0]  long_run_blinks;
   } cfg_type;

   // head of the click queue as seen by the back end
   typedef struct packed {
      logic      valid;
      click_type click;
   } click_beat_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_CLICK_TICKS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_CLICK_TICKS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_HALF_PERIOD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GESTURE_WINDOW    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARTY_ON_TICKS    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARTY_OFF_TICKS   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_RUN_BLINKS  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_RUN_BLINKS   = 3'd7;

   localparam cfg_type CFG_RESET = '{
      short_click_ticks: 16'd500,
      long_click_ticks:  16'd10000,
      blink_half_period: 16'd9000,
      gesture_window:    16'd10000,
      party_on_ticks:    16'd1000,
      party_off_ticks:   16'd4000,
      short_run_blinks:  8'd3,
      long_run_blinks:   8'd100
   };

   localparam logic [7:0] HAZARD_BLINKS      = 8'd10;
   localparam logic [4:0] PARTY_LAST_PHASE   = 5'd16;
   localparam logic [4:0] PARTY_QUIET_PHASE  = 5'd8;
   localparam logic [4:0] PARTY_RIGHT_PHASE  = 5'd4;
   localparam logic [2:0] ALTERNATE_TO_HAZARD = 3'd2;
   localparam logic [2:0] REPEAT_TO_PARTY     = 3'd4;

   // count up, holding at seven
   function automatic logic [2:0] sat7(input logic [2:0] value);
      sat7 = (value == 3'd7) ? value : value + 3'd1;
   endfunction

endpackage

[src/tsf_front.sv]
`timescale 1ns / 1ps

module tsf_front (
   input  logic               clock,
   input  logic               reset,
   input  tsf_pkg::cfg_type   cfg,
   input  logic               accept,
   input  logic               left_pressed,
   input  logic               right_pressed,
   output tsf_pkg::click_type click
);
   import tsf_pkg::*;

   logic [15:0] left_hold_ff, left_hold_in;
   logic [15:0] right_hold_ff, right_hold_in;
   logic [15:0] window_timer_ff, window_timer_in;
   side_type    last_side_ff, last_side_in;
   logic [2:0]  alternation_ff, alternation_in;
   logic [2:0]  repeat_left_ff, repeat_left_in;

   logic [15:0] left_next, right_next, window_next;
   click_type   click_raw;

   always_comb begin
      left_next  = left_pressed ?
                   ((left_hold_ff == 16'hFFFF) ? left_hold_ff : left_hold_ff + 16'd1) : '0;
      right_next = right_pressed ?
                   ((right_hold_ff == 16'hFFFF) ? right_hold_ff : right_hold_ff + 16'd1) : '0;
      // both held cancels both
      if (left_next != '0 && right_next != '0) begin
         left_next  = '0;
         right_next = '0;
      end

      left_hold_in  = left_next;
      right_hold_in = right_next;
      click_raw     = CLICK_NONE;
      priority if (left_next != '0 && left_next == cfg.short_click_ticks) begin
         click_raw = CLICK_LSHORT;
      end else if (right_next != '0 && right_next == cfg.short_click_ticks) begin
         click_raw = CLICK_RSHORT;
      end else if (left_next != '0 && left_next >= cfg.long_click_ticks) begin
         click_raw    = CLICK_LLONG;
         left_hold_in = cfg.long_click_ticks;
      end else if (right_next != '0 && right_next >= cfg.long_click_ticks) begin
         click_raw     = CLICK_RLONG;
         right_hold_in = cfg.long_click_ticks;
      end else begin
         click_raw = CLICK_NONE;
      end

      last_side_in   = last_side_ff;
      alternation_in = alternation_ff;
      repeat_left_in = repeat_left_ff;
      window_next    = window_timer_ff;
      if (click_raw == CLICK_LSHORT) begin
         if (last_side_ff == SIDE_RIGHT) alternation_in = sat7(alternation_ff);
         if (last_side_ff == SIDE_LEFT)  repeat_left_in = sat7(repeat_left_ff);
         window_next  = cfg.gesture_window;
         last_side_in = SIDE_LEFT;
      end else if (click_raw == CLICK_RSHORT) begin
         if (last_side_ff == SIDE_LEFT) alternation_in = sat7(alternation_ff);
         window_next  = cfg.gesture_window;
         last_side_in = SIDE_RIGHT;
      end

      if (window_next != '0) begin
         window_timer_in = window_next - 16'd1;
      end else begin
         window_timer_in = '0;
         last_side_in    = SIDE_NONE;
         alternation_in  = '0;
         repeat_left_in  = '0;
      end

      // gestures override the plain click, party last
      click = click_raw;
      if (alternation_in >= ALTERNATE_TO_HAZARD) click = CLICK_HAZARD;
      if (repeat_left_in >= REPEAT_TO_PARTY)     click = CLICK_PARTY;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_hold_ff    <= '0;
         right_hold_ff   <= '0;
         window_timer_ff <= '0;
         last_side_ff    <= SIDE_NONE;
         alternation_ff  <= '0;
         repeat_left_ff  <= '0;
      end else if (accept) begin
         left_hold_ff    <= left_hold_in;
         right_hold_ff   <= right_hold_in;
         window_timer_ff <= window_timer_in;
         last_side_ff    <= last_side_in;
         alternation_ff  <= alternation_in;
         repeat_left_ff  <= repeat_left_in;
      end
   end

   a_holds_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(left_hold_ff != '0 && right_hold_ff != '0))
      else $error("both hold counters running");

   a_no_side_no_count: assert property (@(posedge clock) disable iff (reset)
      last_side_ff == SIDE_NONE |-> (alternation_ff == '0 && repeat_left_ff == '0))
      else $error("gesture counts kept without a click side");

   a_idle_keeps_state: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(left_hold_ff) && $stable(window_timer_ff)))
      else $error("front state moved without a beat");

endmodule

[src/tsf_queue.sv]
`timescale 1ns / 1ps

module tsf_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tsf_pkg::click_type      push_click,
   input  logic                    pop,
   output logic                    full,
   output tsf_pkg::click_beat_type head
);
   import tsf_pkg::*;

   localparam int unsigned DEPTH = 2;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   click_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? PTR_W'((int'(wr_ptr_ff) + 1) % DEPTH) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'((int'(rd_ptr_ff) + 1) % DEPTH) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.click = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_click;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

endmodule

[src/tsf_back.sv]
`timescale 1ns / 1ps

module tsf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  tsf_pkg::cfg_type        cfg,
   input  tsf_pkg::click_beat_type head,
   output logic                    pop,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic                    left_lamp,
   output logic                    right_lamp,
   output logic [2:0]              mode_now
);
   import tsf_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [7:0]  blinks_ff, blinks_in;
   logic [15:0] timer_ff, timer_in;
   logic [4:0]  phase_ff, phase_in;
   logic [1:0]  lamp_ff, lamp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // the state registers double as the result register
   assign pop          = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = pop ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_comb begin
      mode_in   = mode_ff;
      blinks_in = blinks_ff;
      timer_in  = timer_ff;
      phase_in  = phase_ff;
      lamp_in   = lamp_ff;

      // apply the click
      unique case (head.click)
         CLICK_HAZARD: begin
            if (mode_ff != MODE_HAZARD) begin
               mode_in   = MODE_HAZARD;
               blinks_in = HAZARD_BLINKS;
               timer_in  = '0;
               phase_in  = '0;
            end
         end
         CLICK_PARTY: begin
            if (mode_ff != MODE_PARTY) begin
               mode_in   = MODE_PARTY;
               blinks_in = HAZARD_BLINKS;
               timer_in  = '0;
               phase_in  = '0;
            end
         end
         CLICK_LSHORT, CLICK_RSHORT: begin
            // short on other side restarts phase; cancels longer run
            if ((head.click == CLICK_LSHORT && mode_ff == MODE_RIGHT) ||
                (head.click == CLICK_RSHORT && mode_ff == MODE_LEFT)) begin
               timer_in = '0;
               phase_in = '0;
            end
            mode_in = (head.click == CLICK_LSHORT) ? MODE_LEFT : MODE_RIGHT;
            if (blinks_ff > cfg.short_run_blinks) begin
               blinks_in = '0;
               phase_in  = 5'd1;
            end else begin
               blinks_in = cfg.short_run_blinks;
            end
         end
         CLICK_LLONG: begin
            mode_in   = MODE_LEFT;
            blinks_in = cfg.long_run_blinks;
         end
         CLICK_RLONG: begin
            mode_in   = MODE_RIGHT;
            blinks_in = cfg.long_run_blinks;
         end
         default: begin
         end
      endcase

      // step the flasher
      unique case (mode_in)
         MODE_LEFT, MODE_RIGHT, MODE_HAZARD: begin
            if (timer_in == '0) begin
               if (phase_in == '0) begin
                  timer_in = cfg.blink_half_period;
                  phase_in = 5'd1;
                  unique case (mode_in)
                     MODE_LEFT:  lamp_in = 2'b01;
                     MODE_RIGHT: lamp_in = 2'b10;
                     default:    lamp_in = 2'b11;
                  endcase
               end else begin
                  phase_in = '0;
                  lamp_in  = 2'b00;
                  if (blinks_in != '0 && mode_in != MODE_HAZARD) begin
                     blinks_in = blinks_in - 8'd1;
                  end
                  if (blinks_in == '0) begin
                     mode_in = MODE_IDLE;
                  end else begin
                     timer_in = cfg.blink_half_period;
                  end
               end
            end else begin
               timer_in = timer_in - 16'd1;
            end
         end
         MODE_PARTY: begin
            if (timer_in == '0) begin
               if (phase_in < PARTY_QUIET_PHASE) begin
                  if (phase_in[0]) begin
                     lamp_in  = 2'b00;
                     timer_in = cfg.party_off_ticks;
                  end else begin
                     lamp_in  = (phase_in < PARTY_RIGHT_PHASE) ? 2'b01 : 2'b10;
                     timer_in = cfg.party_on_ticks;
                  end
               end
               phase_in = (phase_in >= PARTY_LAST_PHASE) ? '0 : phase_in + 5'd1;
            end else begin
               timer_in = timer_in - 16'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         blinks_ff    <= '0;
         timer_ff     <= '0;
         phase_ff     <= '0;
         lamp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            mode_ff   <= mode_in;
            blinks_ff <= blinks_in;
            timer_ff  <= timer_in;
            phase_ff  <= phase_in;
            lamp_ff   <= lamp_in;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign left_lamp  = lamp_ff[0];
   assign right_lamp = lamp_ff[1];
   assign mode_now   = mode_ff;

   a_party_sticks: assert property (@(posedge clock) disable iff (reset)
      (pop && head.click == CLICK_PARTY) |=> mode_ff == MODE_PARTY)
      else $error("party click did not leave party mode");

   a_hold_without_pop: assert property (@(posedge clock) disable iff (reset)
      !pop |=> ($stable(mode_ff) && $stable(lamp_ff) && $stable(timer_ff)))
      else $error("flasher state moved without a beat");

   a_pop_gives_result: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("processed beat not presented");

endmodule

[src/turn_signal_flasher_controller_unit.sv]
`timescale 1ns / 1ps

// Turn signal flasher controller. One req beat is one timebase tick carrying the two
// button levels; every req beat gives exactly one rsp beat with both lamp levels and the
// flasher mode after that tick (0 idle, 1 left, 2 right, 3 hazard, 4 party). The front end
// debounces the buttons with hold counters, turns them into short and long clicks and
// spots the hazard and party gestures; the back end runs the blink and party sequencers.
// A two-beat click queue sits between them, so req is taken every clock while rsp keeps
// flowing: one beat per clock sustained. A beat passes through the click queue entry
// register, then the back end state register that also holds the result.
// req_stall rises only when the back end has been stalled long enough to fill the queue.
// The csr port writes one of the eight settings registers per clock and must only be used
// while no beat is in flight.

module turn_signal_flasher_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   // config write port
   input  logic                                csr_write,
   input  logic [tsf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tsf_pkg::CSR_DATA_W-1:0]      csr_data,
   // tick input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_left_pressed,
   input  logic                                req_right_pressed,
   // lamp result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_left_lamp,
   output logic                                rsp_right_lamp,
   output logic [2:0]                          rsp_mode_now
);
   import tsf_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   logic           req_accept;
   click_type      front_click;
   logic           queue_full;
   logic           queue_pop;
   click_beat_type queue_head;

   // settings registers, 8-bit ones take the low data byte
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SHORT_CLICK_TICKS: cfg_in.short_click_ticks = csr_data;
            CSR_LONG_CLICK_TICKS:  cfg_in.long_click_ticks  = csr_data;
            CSR_BLINK_HALF_PERIOD: cfg_in.blink_half_period = csr_data;
            CSR_GESTURE_WINDOW:    cfg_in.gesture_window    = csr_data;
            CSR_PARTY_ON_TICKS:    cfg_in.party_on_ticks    = csr_data;
            CSR_PARTY_OFF_TICKS:   cfg_in.party_off_ticks   = csr_data;
            CSR_SHORT_RUN_BLINKS:  cfg_in.short_run_blinks  = csr_data[7:0];
            CSR_LONG_RUN_BLINKS:   cfg_in.long_run_blinks   = csr_data[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // a tick is taken whenever the click queue has room
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;

   // button qualifying and gesture detection
   tsf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .accept        (req_accept),
      .left_pressed  (req_left_pressed),
      .right_pressed (req_right_pressed),
      .click         (front_click)
   );

   // decouples the two halves
   tsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_click (front_click),
      .pop        (queue_pop),
      .full       (queue_full),
      .head       (queue_head)
   );

   // mode and lamp sequencing, drives the result channel
   tsf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (queue_head),
      .pop        (queue_pop),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .left_lamp  (rsp_left_lamp),
      .right_lamp (rsp_right_lamp),
      .mode_now   (rsp_mode_now)
   );

endmodule

[tb/turn_signal_flasher_controller_unit_tb.sv]
`timescale 1ns / 1ps

module turn_signal_flasher_controller_unit_tb;
   import tsf_pkg::*;

   localparam int CYCLE_LIMIT     = 150000;
   localparam int RSP_HOLD_CYCLES = 64;

   // one lamp beat as it leaves the block
   typedef struct packed {
      logic     left_lamp;
      logic     right_lamp;
      mode_type mode_now;
   } lamp_beat_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_left_pressed = 1'b0;
   logic                   req_right_pressed = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_left_lamp;
   logic                   rsp_right_lamp;
   logic [2:0]             rsp_mode_now;

   turn_signal_flasher_controller_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_left_pressed  (req_left_pressed),
      .req_right_pressed (req_right_pressed),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_lamp     (rsp_left_lamp),
      .rsp_right_lamp    (rsp_right_lamp),
      .rsp_mode_now      (rsp_mode_now)
   );

   always #4 clock = ~clock;

   // run bookkeeping
   lamp_beat_type lamp_expect_q[$];
   int         errors = 0;
   int         cycle_count = 0;
   int         ticks_sent = 0;
   int         settings_used = 0;
   int         hazard_starts = 0;
   int         party_starts = 0;
   int         input_stall_cycles = 0;
   bit         jitter_on = 1'b1;      // random gaps on both sides when set
   bit         rsp_hold_request = 1'b0;

   // ---------------------------------------------------------------
   // flasher prediction: own copy of settings and state
   // ---------------------------------------------------------------
   cfg_type    p_cfg;
   logic [15:0] p_left_hold, p_right_hold, p_window, p_phase_timer;
   side_type   p_last_side;
   logic [2:0] p_alt_count, p_rep_count;
   mode_type   p_mode;
   logic [4:0] p_phase;
   logic [7:0] p_blinks;
   logic [1:0] p_lamps;           // bit 0 left, bit 1 right

   function automatic void reset_prediction();
      p_cfg         = CFG_RESET;
      p_left_hold   = '0;
      p_right_hold  = '0;
      p_window      = '0;
      p_phase_timer = '0;
      p_last_side   = SIDE_NONE;
      p_alt_count   = '0;
      p_rep_count   = '0;
      p_mode        = MODE_IDLE;
      p_phase       = '0;
      p_blinks      = '0;
      p_lamps       = '0;
   endfunction

   // gesture counters hold at seven
   function automatic logic [2:0] bump7(input logic [2:0] v);
      return (v < 3'd7) ? v + 3'd1 : 3'd7;
   endfunction

   // short click: start a short run, or cancel a longer one in progress
   function automatic void start_short_run(input mode_type side, input mode_type other);
      if (p_mode == other) begin
         p_phase_timer = '0;
         p_phase       = '0;
      end
      p_mode = side;
      if (p_blinks > p_cfg.short_run_blinks) begin
         p_blinks = '0;
         p_phase  = 5'd1;
      end else begin
         p_blinks = p_cfg.short_run_blinks;
      end
   endfunction

   // advance the prediction by one tick and return the lamp beat it gives
   function automatic lamp_beat_type flasher_tick(input logic lp, input logic rp);
      click_type     ck;
      lamp_beat_type beat;
      ck = CLICK_NONE;

      // hold counters, both pressed clears both
      if (lp) begin
         if (p_left_hold != 16'hFFFF) p_left_hold++;
      end else begin
         p_left_hold = '0;
      end
      if (rp) begin
         if (p_right_hold != 16'hFFFF) p_right_hold++;
      end else begin
         p_right_hold = '0;
      end
      if (p_left_hold != 0 && p_right_hold != 0) begin
         p_left_hold  = '0;
         p_right_hold = '0;
      end

      // click detection, short takes priority, long clamps the counter
      if (p_left_hold != 0 && p_left_hold == p_cfg.short_click_ticks) begin
         ck = CLICK_LSHORT;
      end else if (p_right_hold != 0 && p_right_hold == p_cfg.short_click_ticks) begin
         ck = CLICK_RSHORT;
      end else if (p_left_hold != 0 && p_left_hold >= p_cfg.long_click_ticks) begin
         ck = CLICK_LLONG;
         p_left_hold = p_cfg.long_click_ticks;
      end else if (p_right_hold != 0 && p_right_hold >= p_cfg.long_click_ticks) begin
         ck = CLICK_RLONG;
         p_right_hold = p_cfg.long_click_ticks;
      end

      // gesture tracking inside the window
      if (ck == CLICK_LSHORT) begin
         if (p_last_side == SIDE_RIGHT) p_alt_count = bump7(p_alt_count);
         if (p_last_side == SIDE_LEFT) p_rep_count = bump7(p_rep_count);
         p_window    = p_cfg.gesture_window;
         p_last_side = SIDE_LEFT;
      end else if (ck == CLICK_RSHORT) begin
         if (p_last_side == SIDE_LEFT) p_alt_count = bump7(p_alt_count);
         p_window    = p_cfg.gesture_window;
         p_last_side = SIDE_RIGHT;
      end
      if (p_window > 0) begin
         p_window--;
      end else begin
         p_last_side = SIDE_NONE;
         p_alt_count = '0;
         p_rep_count = '0;
      end
      if (p_alt_count >= ALTERNATE_TO_HAZARD) ck = CLICK_HAZARD;
      if (p_rep_count >= REPEAT_TO_PARTY) ck = CLICK_PARTY;

      case (ck)
         CLICK_HAZARD: begin
            if (p_mode != MODE_HAZARD) begin
               p_mode        = MODE_HAZARD;
               p_blinks      = HAZARD_BLINKS;
               p_phase_timer = '0;
               p_phase       = '0;
               hazard_starts++;
            end
         end
         CLICK_PARTY: begin
            if (p_mode != MODE_PARTY) begin
               p_mode        = MODE_PARTY;
               p_blinks      = HAZARD_BLINKS;
               p_phase_timer = '0;
               p_phase       = '0;
               party_starts++;
            end
         end
         CLICK_LSHORT: start_short_run(MODE_LEFT, MODE_RIGHT);
         CLICK_RSHORT: start_short_run(MODE_RIGHT, MODE_LEFT);
         CLICK_LLONG: begin
            p_mode   = MODE_LEFT;
            p_blinks = p_cfg.long_run_blinks;
         end
         CLICK_RLONG: begin
            p_mode   = MODE_RIGHT;
            p_blinks = p_cfg.long_run_blinks;
         end
         default: ;
      endcase

      // blink sequencer, any nonzero phase is the lit half
      if (p_mode == MODE_LEFT || p_mode == MODE_RIGHT || p_mode == MODE_HAZARD) begin
         if (p_phase_timer == 0) begin
            if (p_phase == 0) begin
               p_phase_timer = p_cfg.blink_half_period;
               p_phase       = 5'd1;
               case (p_mode)
                  MODE_LEFT:  p_lamps = 2'b01;
                  MODE_RIGHT: p_lamps = 2'b10;
                  default:    p_lamps = 2'b11;
               endcase
            end else begin
               p_phase = '0;
               p_lamps = 2'b00;
               if (p_blinks > 0 && p_mode != MODE_HAZARD) p_blinks--;
               if (p_blinks == 0) p_mode = MODE_IDLE;
               else p_phase_timer = p_cfg.blink_half_period;
            end
         end else begin
            p_phase_timer--;
         end
      end else if (p_mode == MODE_PARTY) begin
         // party pattern, upper phases are quiet single ticks
         if (p_phase_timer == 0) begin
            if (p_phase < PARTY_QUIET_PHASE) begin
               if (p_phase[0]) begin
                  p_lamps       = 2'b00;
                  p_phase_timer = p_cfg.party_off_ticks;
               end else begin
                  p_lamps       = (p_phase < PARTY_RIGHT_PHASE) ? 2'b01 : 2'b10;
                  p_phase_timer = p_cfg.party_on_ticks;
               end
            end
            if (p_phase >= PARTY_LAST_PHASE) p_phase = '0;
            else p_phase++;
         end else begin
            p_phase_timer--;
         end
      end

      beat.left_lamp  = p_lamps[0];
      beat.right_lamp = p_lamps[1];
      beat.mode_now   = p_mode;
      return beat;
   endfunction

   // ---------------------------------------------------------------
   // monitor: predict on each tick beat, compare each lamp beat
   // ---------------------------------------------------------------
   task automatic flag_field(input string name, input int want, input int got);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
   endtask

   always @(posedge clock) begin : lamp_monitor
      lamp_beat_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            lamp_expect_q.push_back(flasher_tick(req_left_pressed, req_right_pressed));
         if (req_valid && req_stall) input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (lamp_expect_q.size() == 0) begin
               errors++;
               $display("%0t: lamp beat with nothing expected, expected none actual %b %b %0d",
                        $time, rsp_left_lamp, rsp_right_lamp, rsp_mode_now);
            end else begin
               want = lamp_expect_q.pop_front();
               if (rsp_left_lamp !== want.left_lamp)
                  flag_field("left_lamp", int'(want.left_lamp), int'(rsp_left_lamp));
               if (rsp_right_lamp !== want.right_lamp)
                  flag_field("right_lamp", int'(want.right_lamp), int'(rsp_right_lamp));
               if (rsp_mode_now !== want.mode_now)
                  flag_field("mode_now", int'(want.mode_now), int'(rsp_mode_now));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // lamp side: random stall before each beat, plus one long hold-off on request
   initial begin : lamp_receiver
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = jitter_on ? $urandom_range(0, 6) : 0;
         if (rsp_hold_request) begin
            hold = RSP_HOLD_CYCLES;
            rsp_hold_request = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // one tick beat; valid stays high into the next call when no gap is drawn
   task automatic send_tick(input logic lp, input logic rp);
      int gap;
      gap = jitter_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_left_pressed  <= lp;
      req_right_pressed <= rp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic hold_button(input logic lp, input logic rp, input int ticks,
                              input int release_ticks);
      repeat (ticks) send_tick(lp, rp);
      repeat (release_ticks) send_tick(1'b0, 1'b0);
   endtask

   // drop valid and wait until every lamp beat is back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (lamp_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_INDEX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
   endtask

   // all eight registers back to back; junk in the unused upper byte of narrow ones
   task automatic apply_settings(input cfg_type c);
      put_reg(CSR_SHORT_CLICK_TICKS, c.short_click_ticks);
      put_reg(CSR_LONG_CLICK_TICKS, c.long_click_ticks);
      put_reg(CSR_BLINK_HALF_PERIOD, c.blink_half_period);
      put_reg(CSR_GESTURE_WINDOW, c.gesture_window);
      put_reg(CSR_PARTY_ON_TICKS, c.party_on_ticks);
      put_reg(CSR_PARTY_OFF_TICKS, c.party_off_ticks);
      put_reg(CSR_SHORT_RUN_BLINKS, {8'($urandom), c.short_run_blinks});
      put_reg(CSR_LONG_RUN_BLINKS, {8'($urandom), c.long_run_blinks});
      csr_write <= 1'b0;
      p_cfg = c;
      settings_used++;
   endtask

   function automatic cfg_type make_cfg(input logic [15:0] short_t, input logic [15:0] long_t,
                                        input logic [15:0] half_t, input logic [15:0] window_t,
                                        input logic [15:0] on_t, input logic [15:0] off_t,
                                        input logic [7:0] short_n, input logic [7:0] long_n);
      cfg_type c;
      c.short_click_ticks = short_t;
      c.long_click_ticks  = long_t;
      c.blink_half_period = half_t;
      c.gesture_window    = window_t;
      c.party_on_ticks    = on_t;
      c.party_off_ticks   = off_t;
      c.short_run_blinks  = short_n;
      c.long_run_blinks   = long_n;
      return c;
   endfunction

   // press lengths that land on the thresholds when those are reachable
   function automatic int short_len();
      if (p_cfg.short_click_ticks >= 1 && p_cfg.short_click_ticks <= 8)
         return int'(p_cfg.short_click_ticks);
      return $urandom_range(1, 8);
   endfunction

   function automatic int long_len();
      if (p_cfg.long_click_ticks >= 1 && p_cfg.long_click_ticks <= 12)
         return int'(p_cfg.long_click_ticks) + $urandom_range(0, 3);
      return $urandom_range(1, 12);
   endfunction

   // random mix of well-formed gestures and noise
   task automatic play_gestures(input int n);
      int   stop_at;
      int   len;
      logic side;
      stop_at = ticks_sent + n;
      while (ticks_sent < stop_at) begin
         if ($urandom_range(0, 7) == 0) jitter_on = ~jitter_on;
         side = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0, 1, 2: hold_button(side, ~side, short_len(), $urandom_range(1, 3));
            3: hold_button(side, ~side, long_len(), $urandom_range(1, 2));
            4: begin
               // alternating clicks toward hazard
               repeat ($urandom_range(2, 4)) begin
                  hold_button(side, ~side, short_len(), 1);
                  side = ~side;
               end
            end
            5: repeat ($urandom_range(4, 6)) hold_button(1'b1, 1'b0, short_len(), 1);
            6: repeat ($urandom_range(1, 6))
               send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            7: begin
               // one button, then both together
               hold_button(side, ~side, $urandom_range(0, 2), 0);
               hold_button(1'b1, 1'b1, $urandom_range(1, 3), $urandom_range(0, 2));
            end
            8: hold_button(1'b0, 1'b0, $urandom_range(1, 10), 0);
            default: begin
               // press just around the short threshold
               len = short_len() + $urandom_range(0, 2);
               hold_button(side, ~side, (len > 1) ? len - 1 : len, 1);
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // reset settings, no click can happen: plain levels and both buttons
   task automatic test_button_levels();
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      settle();
   endtask

   // short, long, hazard, cancel and party by hand
   task automatic test_click_gestures();
      apply_settings(make_cfg(16'd1, 16'd3, 16'd1, 16'd6, 16'd1, 16'd2, 8'd2, 8'd5));
      hold_button(1'b1, 1'b0, 1, 1);      // left short run
      hold_button(1'b0, 1'b1, 1, 1);      // right takes over
      hold_button(1'b1, 1'b0, 1, 1);      // second alternation arms hazard
      hold_button(1'b0, 1'b0, 6, 0);      // let the window lapse
      hold_button(1'b1, 1'b0, 4, 1);      // short cancels hazard, then long run
      repeat (5) hold_button(1'b1, 1'b0, 1, 1);   // left repeats arm party
      hold_button(1'b0, 1'b0, 3, 0);
      send_tick(1'b1, 1'b1);
      settle();
   endtask

   // gesture traffic under quick and random settings
   task automatic test_random_traffic();
      apply_settings(make_cfg(16'd2, 16'd5, 16'd2, 16'd8, 16'd1, 16'd2, 8'd3, 8'd6));
      play_gestures(60);
      settle();
      repeat (3) begin
         apply_settings(make_cfg(16'($urandom_range(1, 6)), 16'($urandom_range(2, 12)),
                                 16'($urandom_range(1, 4)), 16'($urandom_range(1, 24)),
                                 16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                                 8'($urandom_range(0, 6)), 8'($urandom_range(0, 12))));
         play_gestures(45);
         settle();
      end
   endtask

   // ends of the register ranges and the odd threshold combinations
   task automatic test_setting_extremes();
      // lowest values, zero timer loads and zero run lengths
      apply_settings(make_cfg(16'd1, 16'd2, 16'd1, 16'd1, 16'd0, 16'd0, 8'd0, 8'd0));
      play_gestures(50);
      settle();
      // zero short threshold and zero gesture window
      apply_settings(make_cfg(16'd0, 16'd3, 16'd3, 16'd0, 16'd2, 16'd0, 8'd1, 8'd255));
      play_gestures(40);
      settle();
      // short threshold above long, counter clamps first
      apply_settings(make_cfg(16'd7, 16'd4, 16'd1, 16'd20, 16'd3, 16'd1, 8'd2, 8'd1));
      play_gestures(40);
      settle();
      // arm hazard quickly, then carry it into the top of every range
      apply_settings(make_cfg(16'd1, 16'd3, 16'd1, 16'd6, 16'd1, 16'd2, 8'd2, 8'd5));
      hold_button(1'b1, 1'b0, 1, 1);
      hold_button(1'b0, 1'b1, 1, 1);
      hold_button(1'b1, 1'b0, 1, 1);
      settle();
      apply_settings(make_cfg(16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
      play_gestures(30);
      settle();
   endtask

   // lamp side holds off for a long stretch while ticks keep coming
   task automatic test_backpressure();
      apply_settings(make_cfg(16'd2, 16'd5, 16'd2, 16'd8, 16'd1, 16'd2, 8'd3, 8'd6));
      jitter_on        = 1'b0;
      rsp_hold_request = 1'b1;
      play_gestures(40);
      settle();
      jitter_on = 1'b1;
   endtask

   initial begin
      reset_prediction();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_button_levels();
      test_click_gestures();
      test_random_traffic();
      test_setting_extremes();
      test_backpressure();

      repeat (8) @(posedge clock);
      if (lamp_expect_q.size() != 0) begin
         errors += lamp_expect_q.size();
         $display("%0t: %0d lamp beats never arrived", $time, lamp_expect_q.size());
      end
      $display("covered %0d tick beats under %0d register settings", ticks_sent, settings_used);
      $display("hazard armed %0d times, party %0d times, tick side held back %0d cycles",
               hazard_starts, party_starts, input_stall_cycles);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
